>>> design/i2cdbw_pkg.sv
// Shared constants for the I2C display byte writer.
package i2cdbw_pkg;

    // Request codes carried in the req_type field.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Frame layout: start (3 steps), three bytes of nine bit slots (81 steps), stop (3 steps).
    localparam logic [6:0] STEP_IDLE       = 7'd0;
    localparam logic [6:0] STEP_START_HIGH = 7'd1;
    localparam logic [6:0] STEP_START_SDA  = 7'd2;
    localparam logic [6:0] STEP_START_SCL  = 7'd3;
    localparam logic [6:0] STEP_BODY_LAST  = 7'd84;
    localparam logic [6:0] STEP_STOP_SDA   = 7'd85;
    localparam logic [6:0] STEP_STOP_SCL   = 7'd86;
    localparam logic [6:0] FRAME_STEPS     = 7'd87;

    // Sub-step positions inside one bit slot.
    localparam logic [1:0] PHASE_DATA = 2'd0;
    localparam logic [1:0] PHASE_RISE = 2'd1;
    localparam logic [1:0] PHASE_FALL = 2'd2;

    // Bit slot index of the ack slot that follows each byte.
    localparam logic [3:0] BIT_ACK = 4'd8;

    // Byte slots of the frame.
    localparam logic [1:0] SLOT_ADDR = 2'd0;
    localparam logic [1:0] SLOT_CTRL = 2'd1;
    localparam logic [1:0] SLOT_DATA = 2'd2;

    // Control bytes and register reset value.
    localparam logic [7:0] CTRL_DATA  = 8'h40;
    localparam logic [7:0] CTRL_CMD   = 8'h00;
    localparam logic [7:0] ADDR_RESET = 8'h78;

endpackage

>>> design/i2cdbw_if.sv
// Handshake channel interfaces for the I2C display byte writer.
interface i2cdbw_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;
    logic       is_data;

    modport source (output valid, output req_type, output data_byte, output is_data,
                    input ready);
    modport sink   (input valid, input req_type, input data_byte, input is_data,
                    output ready);
endinterface

interface i2cdbw_res_if;
    logic valid;
    logic ready;
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic rejected;

    modport source (output valid, output scl_level, output sda_level, output busy_res,
                    output rejected, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                    input rejected, output ready);
endinterface

interface i2cdbw_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/i2c_display_byte_writer.sv
// Write-only I2C master that steps SCL and SDA through one address/control/data frame.
// A result is registered and becomes valid in the cycle after its input transaction is accepted.
// Throughput: one input transaction per cycle; the single output register is refilled
// in the same cycle that its result is taken, so only a stalled result holds off input.
// Reset: synchronous, active low; idle with both lines high, address register 0x78.
module i2c_display_byte_writer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    i2cdbw_req_if.sink           i_req,
    i2cdbw_res_if.source         o_res,
    i2cdbw_cfg_if.sink           i_cfg
);

    logic       r_out_valid;
    logic       r_rej;
    logic [7:0] r_addr;
    logic [6:0] r_step;
    logic [7:0] r_byte;
    logic       r_mode;
    logic       r_scl;
    logic       r_sda;
    logic [1:0] r_phase;
    logic [3:0] r_bit;
    logic [1:0] r_slot;

    logic       n_rej;
    logic [6:0] n_step;
    logic [7:0] n_byte;
    logic       n_mode;
    logic       n_scl;
    logic       n_sda;
    logic [1:0] n_phase;
    logic [3:0] n_bit;
    logic [1:0] n_slot;

    logic       in_acc;
    logic       busy;
    logic [7:0] slot_byte;
    logic       slot_bit;

    // Input is taken whenever the result register is empty or being emptied.
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign in_acc      = i_req.valid && i_req.ready;
    assign busy        = (r_step != i2cdbw_pkg::STEP_IDLE);

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= i2cdbw_pkg::ADDR_RESET;
        end else if (i_cfg.valid) begin
            r_addr <= i_cfg.data;
        end
    end

    // Byte sent in the current slot and the bit under the bit counter, MSB first.
    always_comb begin
        unique case (r_slot)
            i2cdbw_pkg::SLOT_ADDR: slot_byte = r_addr;
            i2cdbw_pkg::SLOT_CTRL: slot_byte = r_mode ? i2cdbw_pkg::CTRL_DATA
                                                      : i2cdbw_pkg::CTRL_CMD;
            default:               slot_byte = r_byte;
        endcase
        slot_bit = slot_byte[3'd7 - r_bit[2:0]];
    end

    // One frame step, a request load, or the rejection of a write taken while busy, per accepted transaction.
    always_comb begin
        n_rej   = 1'b0;
        n_step  = r_step;
        n_byte  = r_byte;
        n_mode  = r_mode;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_slot  = r_slot;
        if (i_req.req_type == i2cdbw_pkg::REQ_WRITE) begin
            if (busy) begin
                n_rej = 1'b1;
            end else begin
                n_byte  = i_req.data_byte;
                n_mode  = i_req.is_data;
                n_step  = i2cdbw_pkg::STEP_START_HIGH;
                n_phase = i2cdbw_pkg::PHASE_DATA;
                n_bit   = 4'd0;
                n_slot  = i2cdbw_pkg::SLOT_ADDR;
            end
        end else if (busy) begin
            n_step = (r_step == i2cdbw_pkg::FRAME_STEPS) ? i2cdbw_pkg::STEP_IDLE
                                                         : r_step + 7'd1;
            priority if (r_step == i2cdbw_pkg::STEP_START_HIGH) begin
                n_scl = 1'b1;
                n_sda = 1'b1;
            end else if (r_step == i2cdbw_pkg::STEP_START_SDA) begin
                n_sda = 1'b0;
            end else if (r_step == i2cdbw_pkg::STEP_START_SCL) begin
                n_scl = 1'b0;
            end else if (r_step <= i2cdbw_pkg::STEP_BODY_LAST) begin
                unique case (r_phase)
                    i2cdbw_pkg::PHASE_DATA: begin
                        n_sda = (r_bit == i2cdbw_pkg::BIT_ACK) ? 1'b1 : slot_bit;
                    end
                    i2cdbw_pkg::PHASE_RISE: begin
                        n_scl = 1'b1;
                    end
                    default: begin
                        n_scl = 1'b0;
                    end
                endcase
                // Advance phase, then bit slot, then byte slot; the last byte wraps to the first.
                if (r_phase == i2cdbw_pkg::PHASE_FALL) begin
                    n_phase = i2cdbw_pkg::PHASE_DATA;
                    if (r_bit == i2cdbw_pkg::BIT_ACK) begin
                        n_bit  = 4'd0;
                        n_slot = (r_slot == i2cdbw_pkg::SLOT_DATA) ? i2cdbw_pkg::SLOT_ADDR
                                                                   : r_slot + 2'd1;
                    end else begin
                        n_bit = r_bit + 4'd1;
                    end
                end else begin
                    n_phase = r_phase + 2'd1;
                end
            end else if (r_step == i2cdbw_pkg::STEP_STOP_SDA) begin
                n_sda = 1'b0;
            end else if (r_step == i2cdbw_pkg::STEP_STOP_SCL) begin
                n_scl = 1'b1;
            end else begin
                n_sda = 1'b1;
            end
        end
    end

    // Frame state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= i2cdbw_pkg::STEP_IDLE;
            r_byte      <= 8'd0;
            r_mode      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_phase     <= i2cdbw_pkg::PHASE_DATA;
            r_bit       <= 4'd0;
            r_slot      <= i2cdbw_pkg::SLOT_ADDR;
        end else begin
            if (in_acc) begin
                r_out_valid <= 1'b1;
                r_step      <= n_step;
                r_byte      <= n_byte;
                r_mode      <= n_mode;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_phase     <= n_phase;
                r_bit       <= n_bit;
                r_slot      <= n_slot;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rej <= n_rej;
        end
    end

    // The line levels and busy flag are the state left by the last transaction.
    assign o_res.valid     = r_out_valid;
    assign o_res.scl_level = r_scl;
    assign o_res.sda_level = r_sda;
    assign o_res.busy_res  = busy;
    assign o_res.rejected  = r_rej;

    // A write request taken while idle starts the frame at its first step.
    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.req_type == i2cdbw_pkg::REQ_WRITE && !busy)
        |=> (r_step == i2cdbw_pkg::STEP_START_HIGH))
        else $error("write request did not start a frame");

    // A write request taken while busy is reported as rejected and leaves the step alone.
    a_busy_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.req_type == i2cdbw_pkg::REQ_WRITE && busy)
        |=> (o_res.rejected && r_step == $past(r_step)))
        else $error("request during frame not rejected");

    // The step counter never leaves the frame.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step <= i2cdbw_pkg::FRAME_STEPS))
        else $error("step index out of range");

    // Bit-slot counters stay within one byte slot and the three bytes.
    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != 2'd3 && r_bit <= i2cdbw_pkg::BIT_ACK && r_slot != 2'd3))
        else $error("slot counters out of range");

    // Input stalls only while a result waits to be taken.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_out_valid && !o_res.ready))
        else $error("input stalled without a pending result");

endmodule

>>> tb/i2cdbw_pin_checker.sv
// Watches the I2C byte writer channels, predicts every pin result and compares it.
module i2cdbw_pin_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    i2cdbw_req_if  i_req,
    i2cdbw_res_if  i_res,
    i2cdbw_cfg_if  i_cfg,
    output int     o_mismatches,
    output int     o_pending
);

    localparam int STEPS_PER_BIT  = 3;
    localparam int STEPS_PER_BYTE = 27;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic rejected;
    } t_pin_levels;

    // Pin levels still owed by the block, oldest first.
    t_pin_levels expected_levels[$];

    // Private copy of the frame state and the address register.
    logic [7:0] address_reg;
    logic [6:0] next_step;
    logic [7:0] held_byte;
    logic       held_mode;
    logic       scl_line;
    logic       sda_line;
    int         mismatch_count;

    assign o_mismatches = mismatch_count;

    // Byte carried by one of the three byte slots of the frame.
    function automatic logic [7:0] slot_byte(input int slot);
        case (slot)
            i2cdbw_pkg::SLOT_ADDR: return address_reg;
            i2cdbw_pkg::SLOT_CTRL: return held_mode ? i2cdbw_pkg::CTRL_DATA
                                                    : i2cdbw_pkg::CTRL_CMD;
            default:               return held_byte;
        endcase
    endfunction

    // Carry out one pin step of the frame on the private line levels.
    task automatic drive_pins(input logic [6:0] step);
        int         body;
        int         bit_pos;
        logic [1:0] phase;
        logic [7:0] cur_byte;
        if (step == i2cdbw_pkg::STEP_START_HIGH) begin
            scl_line = 1'b1;
            sda_line = 1'b1;
        end else if (step == i2cdbw_pkg::STEP_START_SDA) begin
            sda_line = 1'b0;
        end else if (step == i2cdbw_pkg::STEP_START_SCL) begin
            scl_line = 1'b0;
        end else if (step <= i2cdbw_pkg::STEP_BODY_LAST) begin
            body    = int'(step) - int'(i2cdbw_pkg::STEP_START_SCL) - 1;
            bit_pos = (body % STEPS_PER_BYTE) / STEPS_PER_BIT;
            phase   = 2'((body % STEPS_PER_BYTE) % STEPS_PER_BIT);
            case (phase)
                i2cdbw_pkg::PHASE_DATA: begin
                    if (bit_pos == int'(i2cdbw_pkg::BIT_ACK)) begin
                        sda_line = 1'b1;
                    end else begin
                        cur_byte = slot_byte(body / STEPS_PER_BYTE);
                        sda_line = cur_byte[7 - bit_pos];
                    end
                end
                i2cdbw_pkg::PHASE_RISE: scl_line = 1'b1;
                default:                scl_line = 1'b0;
            endcase
        end else if (step == i2cdbw_pkg::STEP_STOP_SDA) begin
            sda_line = 1'b0;
        end else if (step == i2cdbw_pkg::STEP_STOP_SCL) begin
            scl_line = 1'b1;
        end else begin
            sda_line = 1'b1;
        end
    endtask

    // Work out the pin levels that one accepted request transaction produces.
    task automatic predict_levels(input logic req_type, input logic [7:0] data_byte,
                                  input logic is_data);
        t_pin_levels lv;
        lv.rejected = 1'b0;
        if (req_type == i2cdbw_pkg::REQ_WRITE) begin
            if (next_step != i2cdbw_pkg::STEP_IDLE) begin
                lv.rejected = 1'b1;
            end else begin
                held_byte = data_byte;
                held_mode = is_data;
                next_step = i2cdbw_pkg::STEP_START_HIGH;
            end
        end else if (next_step != i2cdbw_pkg::STEP_IDLE) begin
            drive_pins(next_step);
            next_step = (next_step == i2cdbw_pkg::FRAME_STEPS) ? i2cdbw_pkg::STEP_IDLE
                                                               : next_step + 7'd1;
        end
        lv.scl  = scl_line;
        lv.sda  = sda_line;
        lv.busy = (next_step != i2cdbw_pkg::STEP_IDLE);
        expected_levels.push_back(lv);
    endtask

    task automatic note_mismatch(input string field, input logic want, input logic got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0b, got %0b", field, want, got);
    endtask

    // Results are checked before new requests are predicted: a result never
    // belongs to a request accepted at the same edge.
    always @(posedge i_clk) begin
        t_pin_levels want;
        if (!i_rst_n) begin
            address_reg = i2cdbw_pkg::ADDR_RESET;
            next_step   = i2cdbw_pkg::STEP_IDLE;
            held_byte   = 8'h00;
            held_mode   = 1'b0;
            scl_line    = 1'b1;
            sda_line    = 1'b1;
            expected_levels.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_levels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: scl %0b sda %0b busy %0b rejected %0b",
                                 i_res.scl_level, i_res.sda_level, i_res.busy_res,
                                 i_res.rejected);
                end else begin
                    want = expected_levels.pop_front();
                    if (i_res.scl_level !== want.scl)
                        note_mismatch("scl_level", want.scl, i_res.scl_level);
                    if (i_res.sda_level !== want.sda)
                        note_mismatch("sda_level", want.sda, i_res.sda_level);
                    if (i_res.busy_res !== want.busy)
                        note_mismatch("busy_res", want.busy, i_res.busy_res);
                    if (i_res.rejected !== want.rejected)
                        note_mismatch("rejected", want.rejected, i_res.rejected);
                end
            end
            if (i_cfg.valid && i_cfg.ready)
                address_reg = i_cfg.data;
            if (i_req.valid && i_req.ready)
                predict_levels(i_req.req_type, i_req.data_byte, i_req.is_data);
        end
        o_pending <= expected_levels.size();
    end

endmodule

>>> tb/i2c_display_byte_writer_tb.sv
// Stimulus and verdict for the I2C display byte writer, checked by the pin checker.
module i2c_display_byte_writer_tb;

    localparam int RANDOM_ITEMS = 560;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatch_count;
    int   pending_results;
    int   burst_left;
    int   stall_cycle;

    i2cdbw_req_if req_ch ();
    i2cdbw_res_if res_ch ();
    i2cdbw_cfg_if cfg_ch ();

    i2c_display_byte_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    i2cdbw_pin_checker u_pin_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_results)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result back-pressure: the stall pattern steps in turn through always ready, random and periodic stalls.
    always @(negedge i_clk) begin
        stall_cycle++;
        case ((stall_cycle / 256) % 4)
            0:       res_ch.ready = 1'b1;
            1:       res_ch.ready = 1'($urandom_range(0, 1));
            2:       res_ch.ready = ($urandom_range(0, 3) == 0);
            default: res_ch.ready = ((stall_cycle % 7) < 4);
        endcase
    end

    // Offer one request transaction; bursts of random length with gaps between them.
    task automatic send_item(input logic req_type, input logic [7:0] data_byte,
                             input logic is_data);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        req_ch.valid     = 1'b1;
        req_ch.req_type  = req_type;
        req_ch.data_byte = data_byte;
        req_ch.is_data   = is_data;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(i2cdbw_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic drain;
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_results != 0) @(negedge i_clk);
    endtask

    // Address register writes happen only once the channels are quiet.
    task automatic write_address(input logic [7:0] value);
        drain();
        repeat (3) @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    initial begin
        int       done_items;
        int       frame_left;
        int       next_config;
        int       roll;
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = i2cdbw_pkg::REQ_TICK;
        req_ch.data_byte = 8'h00;
        req_ch.is_data   = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = 8'h00;
        burst_left       = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: idle tick, busy rejection, full frame with reset address.
        send_item(i2cdbw_pkg::REQ_TICK, 8'h00, 1'b0);
        send_item(i2cdbw_pkg::REQ_WRITE, 8'hFF, 1'b1);
        send_item(i2cdbw_pkg::REQ_WRITE, 8'h00, 1'b0);
        send_ticks(88);

        // Directed: command frame with address changed partway through the address byte.
        write_address(8'h00);
        send_item(i2cdbw_pkg::REQ_WRITE, 8'h00, 1'b0);
        send_ticks(10);
        write_address(8'hFF);
        send_ticks(40);
        send_item(i2cdbw_pkg::REQ_WRITE, 8'h5A, 1'b1);
        send_ticks(38);

        // Random: mostly complete frames, some stray requests and idle ticks.
        done_items  = 0;
        frame_left  = 0;
        next_config = 0;
        while (done_items < RANDOM_ITEMS) begin
            if (done_items >= next_config) begin
                case ($urandom_range(0, 5))
                    0:       write_address(8'h00);
                    1:       write_address(8'hFF);
                    default: write_address(8'($urandom));
                endcase
                next_config += $urandom_range(100, 180);
            end
            roll = $urandom_range(0, 99);
            if (frame_left == 0) begin
                if (roll < 85) begin
                    send_item(i2cdbw_pkg::REQ_WRITE, 8'($urandom), 1'($urandom));
                    frame_left = int'(i2cdbw_pkg::FRAME_STEPS);
                    done_items++;
                end else begin
                    send_item(i2cdbw_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
                end
            end else if (roll < 3) begin
                send_item(i2cdbw_pkg::REQ_WRITE, 8'($urandom), 1'($urandom));
            end else begin
                send_item(i2cdbw_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
                frame_left--;
                done_items++;
            end
        end

        drain();
        repeat (4) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("** i2c_display_byte_writer: PASSED **");
        end else begin
            $display("** i2c_display_byte_writer: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake or results that never arrive.
    initial begin
        #400000;
        $display("** i2c_display_byte_writer: FAILED **");
        $finish;
    end

endmodule
